>>> design/life_grid_generation_step_defines.svh
// assertion macros used by the life grid generation step
// no dependencies; included by life_grid_generation_step.sv, which carries concurrent checks
`ifndef LIFE_GRID_GENERATION_STEP_DEFINES_SVH
`define LIFE_GRID_GENERATION_STEP_DEFINES_SVH

`ifndef SYNTHESIS
// check disabled while reset is applied
`define LGS_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);
// check that also holds while reset is applied
`define LGS_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define LGS_ASSERT(label, clk, rst_n, prop, msg)
`define LGS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif

`endif

>>> design/lgs_pkg.sv
// shared codes, field widths and rule constants for the life grid block
// no dependencies
package lgs_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int REQ_W  = 2;
    localparam int ROW_W  = 6;
    localparam int COL_W  = 6;
    localparam int CFG_W  = 7;
    localparam int CIDX_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_READ    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_ADVANCE = 2'd2;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_ACTIVE_WIDTH  = 2'd0;
    localparam logic [CIDX_W-1:0] CFG_ACTIVE_HEIGHT = 2'd1;

    localparam logic [CFG_W-1:0] CFG_RESET_VALUE = 7'd64;

    // b3/s23 thresholds
    localparam logic [3:0] BIRTH_COUNT  = 4'd3;
    localparam logic [3:0] SURVIVE_LOW  = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;

endpackage

>>> design/lgs_row_rule.sv
// one row of the b3/s23 update from the rows above, at and below
// depends on lgs_pkg for the rule thresholds
module lgs_row_rule
    import lgs_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
    input  logic [MAX_WIDTH-1:0] i_prev,
    input  logic [MAX_WIDTH-1:0] i_cur,
    input  logic [MAX_WIDTH-1:0] i_next,
    input  logic [MAX_WIDTH-1:0] i_mask,
    output logic [MAX_WIDTH-1:0] o_row
);

    logic [MAX_WIDTH+1:0] w_p;
    logic [MAX_WIDTH+1:0] w_c;
    logic [MAX_WIDTH+1:0] w_n;

    // inactive columns read as dead, with a dead border either side
    assign w_p = {1'b0, i_prev & i_mask, 1'b0};
    assign w_c = {1'b0, i_cur  & i_mask, 1'b0};
    assign w_n = {1'b0, i_next & i_mask, 1'b0};

    always_comb begin
        logic [3:0] cnt;
        logic       live;
        for (int c = 0; c < MAX_WIDTH; c++) begin
            cnt = 4'(w_p[c]) + 4'(w_p[c+1]) + 4'(w_p[c+2])
                + 4'(w_c[c])                + 4'(w_c[c+2])
                + 4'(w_n[c]) + 4'(w_n[c+1]) + 4'(w_n[c+2]);
            if (i_cur[c]) begin
                live = (cnt >= SURVIVE_LOW) && (cnt <= SURVIVE_HIGH);
            end else begin
                live = (cnt == BIRTH_COUNT);
            end
            o_row[c] = i_mask[c] ? live : i_cur[c];
        end
    end

endmodule

>>> design/life_grid_generation_step.sv
// life grid generation step: cell grid with write, read and advance requests
// sequence: an in-range write or read goes through S_CELL and S_DONE to the result beat, other cell
//   requests straight to S_DONE, advance through the S_ADV sweep; next request taken once the result beat is gone
// throughput: one request at a time, advance bound by the single row update unit
// reset: synchronous, clears the grid (row valid bits), sizes to 64x64, no pending beat
`include "life_grid_generation_step_defines.svh"

module life_grid_generation_step
    import lgs_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [REQ_W-1:0]  i_req_type,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_col,
    input  logic              i_cell_value,
    // result channel
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_cell_out,
    output logic              o_out_of_range,
    // register writes
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CIDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    // address of a grid row, index of a column
    localparam int AW  = $clog2(MAX_HEIGHT);
    localparam int CLW = $clog2(MAX_WIDTH);
    // width for counts and range compares, room for height + 1
    localparam int HW  = $clog2(MAX_HEIGHT + 2);
    localparam int WW  = $clog2(MAX_WIDTH + 1);
    localparam int CW0 = (HW > WW) ? HW : WW;
    localparam int CW  = (CW0 > CFG_W) ? CW0 : CFG_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CELL,
        S_ADV,
        S_DONE
    } t_state;

    // control
    t_state          r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic            r_q_live;

    // request held for the duration of the job
    logic [REQ_W-1:0] r_req_type, n_req_type;
    logic [AW-1:0]    r_row_a, n_row_a;
    logic [CLW-1:0]   r_col_i, n_col_i;
    logic             r_val, n_val;
    logic             r_cell, n_cell;
    logic             r_oor, n_oor;
    logic [CW-1:0]    r_eff_h, n_eff_h;
    logic [MAX_WIDTH-1:0] r_col_mask, n_col_mask;

    // row window for the advance sweep
    logic [MAX_WIDTH-1:0] r_prev, n_prev;
    logic [MAX_WIDTH-1:0] r_cur, n_cur;

    // configuration
    logic [CFG_W-1:0] r_active_width;
    logic [CFG_W-1:0] r_active_height;

    // grid store: one row per entry, a valid bit per row stands in for clearing
    logic [MAX_WIDTH-1:0]  r_mem [MAX_HEIGHT];
    logic [MAX_WIDTH-1:0]  r_q;
    logic [MAX_HEIGHT-1:0] r_row_ok;

    logic                 w_rd_en;
    logic [AW-1:0]        w_rd_addr;
    logic                 w_wr_en;
    logic [AW-1:0]        w_wr_addr;
    logic [MAX_WIDTH-1:0] w_wr_data;

    logic                 w_accept;
    logic [CW-1:0]        w_eff_w;
    logic [CW-1:0]        w_eff_h;
    logic [MAX_WIDTH-1:0] w_mask;
    logic                 w_in_area;
    logic [MAX_WIDTH-1:0] w_q_eff;
    logic [MAX_WIDTH-1:0] w_row_mod;
    logic [MAX_WIDTH-1:0] w_new_row;
    logic [CW-1:0]        w_cnt_m2;

    assign o_cfg_ready    = 1'b1;
    assign o_in_stall     = (r_state != S_IDLE) || r_out_valid;
    assign o_out_valid    = r_out_valid;
    assign o_cell_out     = r_cell;
    assign o_out_of_range = r_oor;

    assign w_accept = i_in_valid && !o_in_stall;

    // register values above the grid size saturate
    assign w_eff_w = (CW'(r_active_width) > CW'(MAX_WIDTH))
                   ? CW'(MAX_WIDTH) : CW'(r_active_width);
    assign w_eff_h = (CW'(r_active_height) > CW'(MAX_HEIGHT))
                   ? CW'(MAX_HEIGHT) : CW'(r_active_height);

    always_comb begin
        for (int c = 0; c < MAX_WIDTH; c++) begin
            w_mask[c] = CW'(c) < w_eff_w;
        end
    end

    assign w_in_area = (CW'(i_row) < w_eff_h) && (CW'(i_col) < w_eff_w);

    // a row never written reads as all dead; nothing read last cycle reads as dead too
    assign w_q_eff  = r_q_live ? r_q : '0;
    assign w_cnt_m2 = r_cnt - CW'(2);

    always_comb begin
        w_row_mod          = w_q_eff;
        w_row_mod[r_col_i] = r_val;
    end

    // shared row update unit, one row per cycle of the sweep
    lgs_row_rule #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_row_rule (
        .i_prev (r_prev),
        .i_cur  (r_cur),
        .i_next (w_q_eff),
        .i_mask (r_col_mask),
        .o_row  (w_new_row)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        n_cnt       = r_cnt;
        n_req_type  = r_req_type;
        n_row_a     = r_row_a;
        n_col_i     = r_col_i;
        n_val       = r_val;
        n_cell      = r_cell;
        n_oor       = r_oor;
        n_eff_h     = r_eff_h;
        n_col_mask  = r_col_mask;
        n_prev      = r_prev;
        n_cur       = r_cur;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_row_a;
        w_wr_en     = 1'b0;
        w_wr_addr   = r_row_a;
        w_wr_data   = w_row_mod;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_req_type = i_req_type;
                    n_row_a    = AW'(i_row);
                    n_col_i    = CLW'(i_col);
                    n_val      = i_cell_value;
                    n_cell     = 1'b0;
                    n_oor      = 1'b0;
                    n_cnt      = '0;
                    n_prev     = '0;
                    n_cur      = '0;
                    n_eff_h    = w_eff_h;
                    n_col_mask = w_mask;
                    case (i_req_type)
                        REQ_WRITE, REQ_READ: begin
                            if (w_in_area) begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = AW'(i_row);
                                n_state   = S_CELL;
                            end else begin
                                n_oor   = 1'b1;
                                n_state = S_DONE;
                            end
                        end
                        REQ_ADVANCE: begin
                            n_state = S_ADV;
                        end
                        default: begin
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_CELL: begin
                // row data of the addressed cell is back from the store
                if (r_req_type == REQ_WRITE) begin
                    w_wr_en = 1'b1;
                end else begin
                    n_cell = w_q_eff[r_col_i];
                end
                n_state = S_DONE;
            end
            S_ADV: begin
                // read row cnt, update row cnt - 2 from the window and the row just read
                w_rd_en   = r_cnt < r_eff_h;
                w_rd_addr = r_cnt[AW-1:0];
                if (r_cnt >= CW'(2)) begin
                    w_wr_en   = 1'b1;
                    w_wr_addr = w_cnt_m2[AW-1:0];
                    w_wr_data = w_new_row;
                end
                n_prev = r_cur;
                n_cur  = w_q_eff;
                n_cnt  = r_cnt + CW'(1);
                if (r_cnt == r_eff_h + CW'(1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_q_live    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_q_live    <= w_rd_en && r_row_ok[w_rd_addr];
        end
        r_cnt      <= n_cnt;
        r_req_type <= n_req_type;
        r_row_a    <= n_row_a;
        r_col_i    <= n_col_i;
        r_val      <= n_val;
        r_cell     <= n_cell;
        r_oor      <= n_oor;
        r_eff_h    <= n_eff_h;
        r_col_mask <= n_col_mask;
        r_prev     <= n_prev;
        r_cur      <= n_cur;
    end

    // grid store, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_q <= r_mem[w_rd_addr];
        end
    end

    // row valid bits, cleared at reset so the whole grid reads dead
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_ok <= '0;
        end else if (w_wr_en) begin
            r_row_ok[w_wr_addr] <= 1'b1;
        end
    end

    // size registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_width  <= CFG_RESET_VALUE;
            r_active_height <= CFG_RESET_VALUE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ACTIVE_WIDTH:  r_active_width  <= i_cfg_data;
                CFG_ACTIVE_HEIGHT: r_active_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // a taken request blocks the next until its beat is produced
    `LGS_ASSERT(a_one_at_a_time, i_clk, i_rst_n, w_accept |=> o_in_stall, "second request taken while busy")
    // sweep writes stay inside the active rows
    `LGS_ASSERT(a_wr_in_rows, i_clk, i_rst_n, (w_wr_en && (r_state == S_ADV)) |-> (CW'(w_wr_addr) < r_eff_h), "advance wrote a row outside the active area")
    // only reads return a live cell
    `LGS_ASSERT(a_cell_only_read, i_clk, i_rst_n, (o_out_valid && o_cell_out) |-> (r_req_type == REQ_READ), "cell value on a non-read beat")
    // range flag only for cell requests
    `LGS_ASSERT(a_oor_only_cell, i_clk, i_rst_n, (o_out_valid && o_out_of_range) |-> ((r_req_type == REQ_WRITE) || (r_req_type == REQ_READ)), "range flag on an advance beat")
    // a result beat appears only as a job ends
    `LGS_ASSERT(a_beat_from_done, i_clk, i_rst_n, $rose(o_out_valid) |-> ($past(r_state) == S_DONE), "result beat without a finished job")

endmodule
